@@ sv/lcs_pkg.sv @@
// shared constants and the token type passed along the lcs cell chain
package lcs_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int SCORE_W     = 7;
  localparam int SYM_W       = 8;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [SYM_W-1:0]   sym;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] diag;
  } lcs_token_t;

endpackage

@@ sv/lcs_cell.sv @@
// one pattern position of the lcs row: stored byte, score and token stage
module lcs_cell
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [IDX_W-1:0] id,
  input  logic [LEN_W-1:0] len,
  input  logic             pat_we,
  input  logic [IDX_W-1:0] pat_idx,
  input  logic [SYM_W-1:0] pat_sym,
  input  logic             clr,
  input  lcs_token_t       tok_in,
  output lcs_token_t       tok_out
);

  logic [SYM_W-1:0]   pat;
  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] v;
  logic               active;

  always_comb begin
    active = ({1'b0, id} < len);
    if (pat == tok_in.sym) begin
      v = tok_in.diag + SCORE_W'(1);
    end else begin
      v = (score > tok_in.left) ? score : tok_in.left;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we && (pat_idx == id)) begin
      pat <= pat_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score   <= '0;
      tok_out <= '0;
    end else begin
      if (clr) begin
        score <= '0;
      end else if (en && tok_in.valid && tok_in.last) begin
        score <= '0;
      end else if (en && tok_in.valid && active) begin
        score <= v;
      end
      if (en) begin
        tok_out.valid <= tok_in.valid;
        tok_out.last  <= tok_in.last;
        tok_out.sym   <= tok_in.sym;
        tok_out.left  <= active ? v : tok_in.left;
        tok_out.diag  <= score;
      end
    end
  end

endmodule

@@ sv/lcs_length_engine.sv @@
// lcs length engine top: pattern loader, systolic cell row and output register
//
// channel  dir  tdata                 tuser    tlast
// s_axis   in   [7:0] symbol          [0] mode  last
// m_axis   out  [6:0] lcs_length      -         -
//
// query words enter every cycle while no result is stalled; each walks the row one cell per cycle,
// and its length is taken from the last cell into the output register after its last query word
// a pattern word waits until no query word is left in the row
// reset clears scores, pattern length and the row; pattern bytes need loading
// a stalled result freezes the whole row until it is taken
module lcs_length_engine
  import lcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [0:0] s_axis_tuser,   // [0] mode
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [6:0] lcs_length, [7] zero
);

  lcs_token_t tok [MAX_PATTERN+1];

  logic [LEN_W-1:0]   pattern_len;
  logic               loading;
  logic [SCORE_W-1:0] out_len;
  logic               en;
  logic               busy;
  logic               accept;
  logic               pat_acc;
  logic [LEN_W-1:0]   base_len;
  logic               fits;
  logic               pat_we;
  logic               clr;

  assign en      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && ((s_axis_tuser[0] == MODE_QUERY) || !busy);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign pat_acc = accept && (s_axis_tuser[0] == MODE_PATTERN);
  assign base_len = loading ? '0 : pattern_len;
  assign fits    = (base_len < LEN_W'(MAX_PATTERN));
  assign pat_we  = pat_acc && fits;
  assign clr     = pat_acc && s_axis_tlast;
  assign m_axis_tdata = {1'b0, out_len};

  always_comb begin
    busy = 1'b0;
    for (int k = 0; k <= MAX_PATTERN; k++) begin
      busy = busy | tok[k].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= '0;
      loading     <= 1'b1;
    end else if (pat_acc) begin
      pattern_len <= base_len + LEN_W'(fits);
      loading     <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else if (en) begin
      tok[0].valid <= accept && (s_axis_tuser[0] == MODE_QUERY);
      tok[0].last  <= s_axis_tlast;
      tok[0].sym   <= s_axis_tdata;
      tok[0].left  <= '0;
      tok[0].diag  <= '0;
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    lcs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .id      (IDX_W'(i)),
      .len     (pattern_len),
      .pat_we  (pat_we),
      .pat_idx (base_len[IDX_W-1:0]),
      .pat_sym (s_axis_tdata),
      .clr     (clr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= tok[MAX_PATTERN].valid && tok[MAX_PATTERN].last;
      out_len       <= tok[MAX_PATTERN].left;
    end
  end

`ifndef SYNTH
  a_pattern_idle: assert property (@(posedge clk) disable iff (rst)
    pat_acc |-> !busy)
    else $error("pattern word taken with query words in the row");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    pattern_len <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(tok[MAX_PATTERN].valid && tok[MAX_PATTERN].last))
    else $error("result without a closing query word");

  a_row_frozen: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(tok[MAX_PATTERN]))
    else $error("row moved while result stalled");
`endif

endmodule

@@ test/lcs_length_checker.sv @@
`timescale 1ns / 1ps
// checker for lcs_length_engine: tracks pattern and score row, predicts and compares lengths
module lcs_length_checker
  import lcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [0:0] s_axis_tuser,   // [0] mode
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [6:0] lcs_length, [7] zero
  output int         pending,
  output int         errors
);

  logic [SYM_W-1:0]   pattern_mem [MAX_PATTERN];
  logic [SCORE_W-1:0] score_row [MAX_PATTERN];
  int                 pattern_len;
  logic               pattern_done;
  logic [SCORE_W-1:0] expected_lengths [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_scores();
    foreach (score_row[j]) score_row[j] = '0;
  endtask

  task automatic absorb_word(input logic mode, input logic [SYM_W-1:0] sym, input logic last);
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] score_val;
    logic [SCORE_W-1:0] final_len;
    int                 j;
    if (mode == MODE_PATTERN) begin
      if (pattern_done) begin
        pattern_len  = 0;
        pattern_done = 1'b0;
      end
      // bytes past the store capacity are dropped
      if (pattern_len < MAX_PATTERN) begin
        pattern_mem[pattern_len] = sym;
        pattern_len++;
      end
      if (last) begin
        clear_scores();
        pattern_done = 1'b1;
      end
    end else begin
      diag = '0;
      left = '0;
      for (j = 0; j < pattern_len; j++) begin
        up = score_row[j];
        if (pattern_mem[j] == sym)
          score_val = diag + 1'b1;
        else
          score_val = (up > left) ? up : left;
        score_row[j] = score_val;
        diag = up;
        left = score_val;
      end
      if (last) begin
        final_len = '0;
        if (pattern_len > 0) final_len = score_row[pattern_len-1];
        expected_lengths = {expected_lengths, final_len};
        clear_scores();
      end
    end
  endtask

  always @(posedge clk) begin
    logic [SCORE_W-1:0] want;
    if (rst) begin
      pattern_len  = 0;
      pattern_done = 1'b1;
      errors       = 0;
      clear_scores();
      expected_lengths.delete();
    end else begin
      // results leave before the word accepted on this edge can have any effect
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_lengths.size() == 0) begin
          report_mismatch($sformatf("length word 0x%02h with none expected", m_axis_tdata));
        end else begin
          want = expected_lengths.pop_front();
          if (m_axis_tdata[SCORE_W-1:0] !== want)
            report_mismatch($sformatf("lcs_length %0d, expected %0d",
                                      m_axis_tdata[SCORE_W-1:0], want));
          if (m_axis_tdata[7] !== 1'b0)
            report_mismatch("padding bit of length word not zero");
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_word(s_axis_tuser[0], s_axis_tdata, s_axis_tlast);
    end
    pending <= expected_lengths.size();
  end

endmodule

@@ test/lcs_length_engine_tb.sv @@
`timescale 1ns / 1ps
// testbench top for lcs_length_engine: clock, reset, pattern and query stimulus, verdict
module lcs_length_engine_tb;
  import lcs_pkg::*;

  localparam int WORD_TARGET = 1900;
  localparam int QUIET_FROM  = 1600;
  localparam int CYCLE_LIMIT = 1000000;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic [0:0] s_axis_tuser  = MODE_PATTERN;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  int         pending;
  int         errors;
  int         words_sent    = 0;
  int         cycle_count   = 0;
  int         stall_left    = 0;
  logic       idle_on       = 1'b1;
  logic [7:0] alphabet [4];
  int         alphabet_size = 0;
  logic [7:0] pattern_copy [$];
  logic       pattern_open  = 1'b0;

  always #10 clk = ~clk;

  lcs_length_engine dut (.*);

  lcs_length_checker length_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lcs_length_engine_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] pick_symbol();
    if (alphabet_size > 0)
      return alphabet[$urandom_range(0, alphabet_size - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic mode, input logic [7:0] sym, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_pattern(input int len, input logic finish);
    logic [7:0] sym;
    int         i;
    if (!pattern_open) pattern_copy.delete();
    for (i = 0; i < len; i++) begin
      sym = pick_symbol();
      if (pattern_copy.size() < MAX_PATTERN) pattern_copy = {pattern_copy, sym};
      send_word(MODE_PATTERN, sym, finish && i == len - 1);
    end
    pattern_open = !finish;
  endtask

  // replay sends the held pattern with a few stray bytes mixed in
  task automatic send_query(input int len, input logic finish, input logic replay);
    logic [7:0] query [$];
    int         i;
    if (replay) begin
      foreach (pattern_copy[k]) begin
        if ($urandom_range(0, 7) == 0) query = {query, pick_symbol()};
        query = {query, pattern_copy[k]};
      end
    end
    while (query.size() < len) query = {query, pick_symbol()};
    for (i = 0; i < query.size(); i++)
      send_word(MODE_QUERY, query[i], finish && i == query.size() - 1);
  endtask

  task automatic wait_for_lengths();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int span;
    int next_hold;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty pattern after reset
    send_word(MODE_QUERY,   8'h00, 1'b1);
    send_word(MODE_QUERY,   8'hFF, 1'b0);
    send_word(MODE_QUERY,   8'h5A, 1'b0);
    send_word(MODE_QUERY,   8'hA5, 1'b1);
    send_word(MODE_PATTERN, 8'h00, 1'b0);
    send_word(MODE_PATTERN, 8'hFF, 1'b0);
    send_word(MODE_PATTERN, 8'h55, 1'b0);
    send_word(MODE_PATTERN, 8'hAA, 1'b1);
    send_word(MODE_QUERY,   8'h00, 1'b0);
    send_word(MODE_QUERY,   8'hAA, 1'b0);
    send_word(MODE_QUERY,   8'hFF, 1'b0);
    send_word(MODE_QUERY,   8'h55, 1'b0);
    send_word(MODE_QUERY,   8'hAA, 1'b1);
    send_word(MODE_QUERY,   8'hAA, 1'b1);
    // queries against an unfinished pattern, which then continues
    send_word(MODE_PATTERN, 8'h41, 1'b0);
    send_word(MODE_PATTERN, 8'h42, 1'b0);
    send_word(MODE_QUERY,   8'h42, 1'b0);
    send_word(MODE_QUERY,   8'h41, 1'b1);
    send_word(MODE_PATTERN, 8'h43, 1'b1);
    send_word(MODE_QUERY,   8'h41, 1'b0);
    send_word(MODE_QUERY,   8'h42, 1'b0);
    send_word(MODE_QUERY,   8'h43, 1'b1);
    send_word(MODE_PATTERN, 8'h7E, 1'b1);
    send_word(MODE_QUERY,   8'h81, 1'b1);

    next_hold = $urandom_range(300, 700);
    while (words_sent < WORD_TARGET) begin
      idle_on <= (words_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      alphabet_size = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          span = $urandom_range(1, 8);
        else if (pick < 93)
          span = $urandom_range(9, MAX_PATTERN);
        else
          span = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 8);
        send_pattern(span, $urandom_range(0, 9) != 0);
      end else if (pick < 90) begin
        span = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 80);
        send_query(span, 1'b1, $urandom_range(0, 4) == 0);
      end else begin
        // query left open, runs into whatever follows
        send_query($urandom_range(1, 6), 1'b0, 1'b0);
      end
      if (words_sent >= next_hold) begin
        wait_for_lengths();
        next_hold = words_sent + $urandom_range(300, 700);
      end
    end

    wait_for_lengths();
    repeat (MAX_PATTERN + 16) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("lcs_length_engine_tb OK");
    else
      $display("lcs_length_engine_tb NOT OK");
    $finish;
  end

endmodule
